// ----- rtl/core/uart_register_datagram_engine_macros.svh -----
// assertion macros shared by the datagram engine rtl
// no dependencies; taken in by `include where assertions are written
`ifndef UART_REGISTER_DATAGRAM_ENGINE_MACROS_SVH
`define UART_REGISTER_DATAGRAM_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define URDE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("urde assertion failed");

// next-cycle implication, disabled during reset
`define URDE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("urde assertion failed");

`endif

// ----- rtl/core/urde_pkg.sv -----
// types, codes and the crc-8 step for the uart register datagram engine
// no dependencies
`timescale 1ns / 1ps

package urde_pkg;

   localparam logic [7:0] SYNC_BYTE  = 8'h05;
   localparam logic [7:0] CRC_POLY   = 8'h07;
   localparam logic [3:0] READ_LEN   = 4'd4;
   localparam logic [3:0] WRITE_LEN  = 4'd8;
   localparam logic [2:0] REPLY_LAST = 3'd7;
   localparam logic [2:0] READ_LAST  = 3'd3;
   localparam logic [2:0] WRITE_LAST = 3'd7;
   localparam logic [2:0] DATA_FIRST = 3'd3;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_RX    = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_REPLY = 2'd2
   } op_type;

   localparam logic KIND_TX    = 1'b0;
   localparam logic KIND_REPLY = 1'b1;

   typedef struct packed {
      op_type      op;
      logic [7:0]  node;
      logic [6:0]  reg_num;
      logic [31:0] data;
      logic        crc_error;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } push_type;

   typedef struct packed {
      logic full;
      logic valid;
   } fifo_stat_type;

   // one byte into the crc, lsb first, crc shifted msb first
   function automatic logic [7:0] crc_feed(input logic [7:0] crc_in,
                                           input logic [7:0] data_in);
      logic [7:0] c;
      c = crc_in;
      for (int i = 0; i < 8; i++) begin
         if (c[7] ^ data_in[i]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- rtl/core/uart_register_datagram_engine.sv -----
// top level of the single-wire uart register datagram engine (master side)
// depends on urde_pkg, urde_front, urde_fifo, urde_back
`timescale 1ns / 1ps
//
// channel  dir  payload
// csr_     in   csr_data: node address
// req_     in   tuser: cmd; tdata: reg_num[6:0], write_data[38:7], rx_byte[46:39]
// rsp_     out  tuser: kind; tlast: last; tdata: tx_byte[7:0], read_data[39:8],
//               crc_error[40]
//
// each req beat is taken while the 4-entry job queue has room
// the serializer emits one rsp beat per cycle while rsp_tready is high: 4 for
// a read frame, 8 for a write, 1 for a finished reply; sustained rate is set
// by that byte-per-cycle serializer; rsp_tready low holds the result register;
// the front keeps taking beats until the queue is full
// reset is synchronous and clears control state only; no clearing pass

module uart_register_datagram_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data,     // node_address
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,    // reg_num, write_data, rx_byte, zero pad
   input  logic [1:0]  req_tuser,    // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,    // tx_byte, read_data, crc_error, zero pad
   output logic        rsp_tuser,    // kind
   output logic        rsp_tlast
);
   import urde_pkg::*;

   push_type      push;
   job_type       head;
   fifo_stat_type fifo_stat;
   logic          pop;

   urde_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .fifo_stat  (fifo_stat),
      .push_out   (push)
   );

   urde_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .head    (head),
      .stat    (fifo_stat)
   );

   urde_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .fifo_stat  (fifo_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- rtl/core/urde_front.sv -----
// front end: takes request and line beats, tracks echo and reply state,
// queues transmit jobs and finished replies; depends on urde_pkg
`timescale 1ns / 1ps

module urde_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [7:0]              csr_data,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [47:0]             req_tdata,
   input  logic [1:0]              req_tuser,
   input  urde_pkg::fifo_stat_type fifo_stat,
   output urde_pkg::push_type      push_out
);
   import urde_pkg::*;

   logic [7:0]  node_address_ff, node_address_in;
   logic [3:0]  echo_left_ff, echo_left_in;
   logic        reply_pending_ff, reply_pending_in;
   logic [2:0]  reply_count_ff, reply_count_in;
   logic [7:0]  reply_crc_ff, reply_crc_in;
   logic [31:0] reply_word_ff, reply_word_in;

   logic        accept;
   cmd_type     cmd;
   logic [6:0]  reg_num;
   logic [31:0] write_data;
   logic [7:0]  rx_byte;
   logic [7:0]  crc_next;

   assign csr_ready  = 1'b1;
   assign req_tready = !fifo_stat.full;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = cmd_type'(req_tuser);
   assign reg_num    = req_tdata[6:0];
   assign write_data = req_tdata[38:7];
   assign rx_byte    = req_tdata[46:39];
   assign crc_next   = crc_feed(reply_crc_ff, rx_byte);

   always_comb begin
      node_address_in  = node_address_ff;
      echo_left_in     = echo_left_ff;
      reply_pending_in = reply_pending_ff;
      reply_count_in   = reply_count_ff;
      reply_crc_in     = reply_crc_ff;
      reply_word_in    = reply_word_ff;
      push_out.push            = 1'b0;
      push_out.job.op          = OP_READ;
      push_out.job.node        = node_address_ff;
      push_out.job.reg_num     = reg_num;
      push_out.job.data        = write_data;
      push_out.job.crc_error   = 1'b0;

      if (csr_valid && csr_ready) begin
         node_address_in = csr_data;
      end

      if (accept) begin
         unique case (cmd) inside
            CMD_READ, CMD_WRITE: begin
               push_out.push    = 1'b1;
               push_out.job.op  = (cmd == CMD_READ) ? OP_READ : OP_WRITE;
               echo_left_in     = (cmd == CMD_READ) ? READ_LEN : WRITE_LEN;
               reply_pending_in = (cmd == CMD_READ);
               reply_count_in   = '0;
               reply_crc_in     = '0;
               reply_word_in    = '0;
            end
            CMD_RX: begin
               if (echo_left_ff != 4'd0) begin
                  echo_left_in = echo_left_ff - 4'd1;
               end else if (reply_pending_ff) begin
                  if (reply_count_ff != REPLY_LAST) begin
                     reply_crc_in   = crc_next;
                     reply_count_in = reply_count_ff + 3'd1;
                     if (reply_count_ff >= DATA_FIRST) begin
                        reply_word_in = {reply_word_ff[23:0], rx_byte};
                     end
                  end else begin
                     push_out.push          = 1'b1;
                     push_out.job.op        = OP_REPLY;
                     push_out.job.data      = reply_word_ff;
                     push_out.job.crc_error = (rx_byte != reply_crc_ff);
                     reply_pending_in       = 1'b0;
                     reply_count_in         = '0;
                     reply_crc_in           = '0;
                     reply_word_in          = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_address_ff  <= '0;
         echo_left_ff     <= '0;
         reply_pending_ff <= 1'b0;
         reply_count_ff   <= '0;
         reply_crc_ff     <= '0;
         reply_word_ff    <= '0;
      end else begin
         node_address_ff  <= node_address_in;
         echo_left_ff     <= echo_left_in;
         reply_pending_ff <= reply_pending_in;
         reply_count_ff   <= reply_count_in;
         reply_crc_ff     <= reply_crc_in;
         reply_word_ff    <= reply_word_in;
      end
   end

endmodule

// ----- rtl/core/urde_fifo.sv -----
// short job queue between front end and serializer
// depends on urde_pkg
`timescale 1ns / 1ps

module urde_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  urde_pkg::push_type      push_in,
   input  logic                    pop,
   output urde_pkg::job_type       head,
   output urde_pkg::fifo_stat_type stat
);
   import urde_pkg::*;

   job_type                 mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign stat.full  = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign stat.valid = (count_ff != '0);
   assign head       = mem[rd_ptr_ff];
   assign do_push    = push_in.push && !stat.full;
   assign do_pop     = pop && stat.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_in.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/core/urde_back.sv -----
// back end: serializes queued jobs into frame bytes with running crc,
// or delivers a finished reply; owns the result register; depends on urde_pkg
`timescale 1ns / 1ps
`include "uart_register_datagram_engine_macros.svh"

module urde_back (
   input  logic                    clock,
   input  logic                    reset,
   input  urde_pkg::job_type       head,
   input  urde_pkg::fifo_stat_type fifo_stat,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [47:0]             rsp_tdata,
   output logic                    rsp_tuser,
   output logic                    rsp_tlast
);
   import urde_pkg::*;

   logic [2:0]  idx_ff, idx_in;
   logic [7:0]  crc_ff, crc_in;
   logic        valid_ff, valid_in;
   logic        kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [31:0] data_ff, data_in;
   logic        err_ff, err_in;

   logic        out_free;
   logic        fire;
   logic        is_reply;
   logic [2:0]  last_idx;
   logic        at_last;
   logic [7:0]  frame_byte;
   logic [7:0]  tx_byte;

   assign out_free = !valid_ff || rsp_tready;
   assign fire     = fifo_stat.valid && out_free;
   assign is_reply = (head.op == OP_REPLY);
   assign last_idx = (head.op == OP_READ) ? READ_LAST : WRITE_LAST;
   assign at_last  = (idx_ff == last_idx);
   assign tx_byte  = at_last ? crc_ff : frame_byte;

   always_comb begin
      unique case (idx_ff)
         3'd0:    frame_byte = SYNC_BYTE;
         3'd1:    frame_byte = head.node;
         3'd2:    frame_byte = {head.op == OP_WRITE, head.reg_num};
         3'd3:    frame_byte = head.data[31:24];
         3'd4:    frame_byte = head.data[23:16];
         3'd5:    frame_byte = head.data[15:8];
         3'd6:    frame_byte = head.data[7:0];
         default: frame_byte = '0;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      crc_in   = crc_ff;
      valid_in = valid_ff && !rsp_tready;
      kind_in  = kind_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      data_in  = data_ff;
      err_in   = err_ff;
      pop      = 1'b0;
      if (fire) begin
         valid_in = 1'b1;
         if (is_reply) begin
            kind_in = KIND_REPLY;
            byte_in = '0;
            last_in = 1'b0;
            data_in = head.data;
            err_in  = head.crc_error;
            pop     = 1'b1;
         end else begin
            kind_in = KIND_TX;
            byte_in = tx_byte;
            last_in = at_last;
            data_in = '0;
            err_in  = 1'b0;
            if (at_last) begin
               pop    = 1'b1;
               idx_in = '0;
               crc_in = '0;
            end else begin
               idx_in = idx_ff + 3'd1;
               crc_in = crc_feed(crc_ff, tx_byte);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         crc_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         crc_ff   <= crc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      data_ff <= data_in;
      err_ff  <= err_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {7'd0, err_ff, data_ff, byte_ff};

   `URDE_ASSERT_NOW(a_read_idx_range, clock, reset,
      fifo_stat.valid && head.op == OP_READ, idx_ff <= READ_LAST)
   `URDE_ASSERT_NOW(a_mid_frame_has_job, clock, reset,
      idx_ff != 3'd0, fifo_stat.valid)
   `URDE_ASSERT_NOW(a_reply_at_frame_start, clock, reset,
      fire && is_reply, idx_ff == 3'd0 && crc_ff == 8'd0)
   `URDE_ASSERT_NEXT(a_reply_beat_not_last, clock, reset,
      fire && is_reply, rsp_tvalid && rsp_tuser == KIND_REPLY && !rsp_tlast)

endmodule
